@@ design/otc_pkg.sv @@
package otc_pkg;

    // result kinds (m_tuser)
    localparam logic [1:0] KIND_APPLY    = 2'd0;
    localparam logic [1:0] KIND_CONTINUE = 2'd1;
    localparam logic [1:0] KIND_SUCCESS  = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // request commands (s_tuser)
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_EDGE  = 1'b1;

    // line levels
    localparam logic LEVEL_LOW  = 1'b0;
    localparam logic LEVEL_HIGH = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_EXPECTED_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN_PULSE      = 2'd1;
    localparam logic [1:0] REG_OPERATING_TRIM = 2'd2;
    localparam logic [1:0] REG_MAX_ROUNDS     = 2'd3;

    // register reset values
    localparam logic [15:0] EXPECTED_COUNT_RST = 16'd8229;
    localparam logic [15:0] MIN_PULSE_RST      = 16'd300;
    localparam logic [7:0]  OPERATING_TRIM_RST = 8'd0;
    localparam logic [5:0]  MAX_ROUNDS_RST     = 6'd31;

    // best error at session start
    localparam logic [15:0] LEAST_ERROR_INIT = 16'hFFFF;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  trim_to_apply;
        logic [7:0]  best_trim;
        logic [15:0] best_error;
        logic [7:0]  correction_delta;
    } result_t;

endpackage

@@ design/oscillator_trim_calibrator.sv @@
// Oscillator trim calibrator.
// Requests enter on the s_ stream: s_tuser is the command (0 begin a sweep
// round, 1 line edge event), s_tdata carries restart, the new line level and
// the 16-bit timestamp of the edge. A begin starts a sweep of STEPS_PER_ROUND
// measurements; each one finds a sync low pulse of at least min_pulse counts,
// then the remaining low pulses of the reference pattern, compares the span
// with expected_count and keeps the best trim. Results leave on the m_ stream:
// m_tuser is the kind (apply trim, round continue, success, error), m_tdata
// the trims, best error and correction delta. Edges that finish nothing give
// no result.
// A request is registered at the input, and its result is loaded into the
// output register once that register is free or is being read.
// Throughput: one request per cycle while the receiver does not stall, set by
// the combinational subtract, absolute value and compare that closes a measurement.
// When the receiver stalls the result is held in the output register and one
// more request may wait in the input register; s_tready drops only then.
// Reset clears the sweep state, the best error to all ones and the registers
// to their defaults. The APB port writes and reads the four registers.
module oscillator_trim_calibrator
    import otc_pkg::*;
#(
    parameter int PULSES_PER_PATTERN = 8,
    parameter int STEPS_PER_ROUND    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // restart, line_level, stamp[15:0], zero pad
    input  logic        s_tuser,   // cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // trim_to_apply, best_trim, best_error, correction_delta
    output logic [1:0]  m_tuser,   // kind

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PC_W = $clog2(PULSES_PER_PATTERN + 1);
    localparam int MI_W = $clog2(STEPS_PER_ROUND + 1);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SYNC_FALL = 3'd1;
    localparam logic [2:0] PH_SYNC_RISE = 3'd2;
    localparam logic [2:0] PH_MEAS_FALL = 3'd3;
    localparam logic [2:0] PH_MEAS_RISE = 3'd4;

    // configuration registers
    logic [15:0] expected_count_reg;
    logic [15:0] min_pulse_reg;
    logic [7:0]  operating_trim_reg;
    logic [5:0]  max_rounds_reg;

    // input register
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic        in_restart_reg;
    logic        in_level_reg;
    logic [15:0] in_stamp_reg;

    // sweep state
    logic [2:0]      phase_reg, phase_next;
    logic [PC_W-1:0] pulse_count_reg, pulse_count_next;
    logic [15:0]     pattern_start_reg, pattern_start_next;
    logic [15:0]     fall_stamp_reg, fall_stamp_next;
    logic [7:0]      sweep_trim_reg, sweep_trim_next;
    logic [MI_W-1:0] measure_index_reg, measure_index_next;
    logic [5:0]      round_count_reg, round_count_next;
    logic [15:0]     least_error_reg, least_error_next;
    logic [7:0]      least_trim_reg, least_trim_next;

    // output register
    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;
    logic    cfg_write;
    logic    emit;
    result_t res;

    // measurement arithmetic
    logic [15:0]     span;
    logic [15:0]     err;
    logic [15:0]     low_pulse;
    logic [PC_W-1:0] pulse_inc;
    logic [MI_W-1:0] index_inc;
    logic [7:0]      trim_inc;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.kind;
    assign m_tdata   = {out_reg.correction_delta, out_reg.best_error,
                        out_reg.best_trim, out_reg.trim_to_apply};
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_EXPECTED_COUNT: prdata = {16'd0, expected_count_reg};
            REG_MIN_PULSE:      prdata = {16'd0, min_pulse_reg};
            REG_OPERATING_TRIM: prdata = {24'd0, operating_trim_reg};
            REG_MAX_ROUNDS:     prdata = {26'd0, max_rounds_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_count_reg <= EXPECTED_COUNT_RST;
            min_pulse_reg      <= MIN_PULSE_RST;
            operating_trim_reg <= OPERATING_TRIM_RST;
            max_rounds_reg     <= MAX_ROUNDS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_EXPECTED_COUNT: expected_count_reg <= pwdata[15:0];
                REG_MIN_PULSE:      min_pulse_reg      <= pwdata[15:0];
                REG_OPERATING_TRIM: operating_trim_reg <= pwdata[7:0];
                REG_MAX_ROUNDS:     max_rounds_reg     <= pwdata[5:0];
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg     <= s_tuser;
            in_restart_reg <= s_tdata[0];
            in_level_reg   <= s_tdata[1];
            in_stamp_reg   <= s_tdata[17:2];
        end
    end

    // span error and increments
    assign span      = in_stamp_reg - pattern_start_reg;
    assign err       = (span > expected_count_reg) ? (span - expected_count_reg)
                                                   : (expected_count_reg - span);
    assign low_pulse = in_stamp_reg - fall_stamp_reg;
    assign pulse_inc = pulse_count_reg + PC_W'(1);
    assign index_inc = measure_index_reg + MI_W'(1);
    assign trim_inc  = sweep_trim_reg + 8'd1;

    // next state and result
    always_comb
    begin
        phase_next         = phase_reg;
        pulse_count_next   = pulse_count_reg;
        pattern_start_next = pattern_start_reg;
        fall_stamp_next    = fall_stamp_reg;
        sweep_trim_next    = sweep_trim_reg;
        measure_index_next = measure_index_reg;
        round_count_next   = round_count_reg;
        least_error_next   = least_error_reg;
        least_trim_next    = least_trim_reg;
        emit               = 1'b0;
        res.kind           = KIND_APPLY;
        res.trim_to_apply  = sweep_trim_reg;
        res.correction_delta = 8'd0;

        if (in_cmd_reg == CMD_BEGIN)
        begin
            emit = 1'b1;
            if (!in_restart_reg && (round_count_reg > max_rounds_reg))
            begin
                // session exhausted
                phase_next         = PH_IDLE;
                measure_index_next = '0;
                res.kind           = KIND_ERROR;
                res.trim_to_apply  = operating_trim_reg;
            end
            else
            begin
                if (in_restart_reg)
                begin
                    round_count_next = 6'd0;
                    sweep_trim_next  = 8'd0;
                    least_error_next = LEAST_ERROR_INIT;
                end
                measure_index_next = '0;
                pulse_count_next   = '0;
                phase_next         = PH_SYNC_FALL;
                res.kind           = KIND_APPLY;
                res.trim_to_apply  = in_restart_reg ? 8'd0 : sweep_trim_reg;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SYNC_FALL:
                begin
                    if (in_level_reg == LEVEL_LOW)
                    begin
                        fall_stamp_next = in_stamp_reg;
                        phase_next      = PH_SYNC_RISE;
                    end
                end
                PH_SYNC_RISE:
                begin
                    if (in_level_reg == LEVEL_HIGH)
                    begin
                        if (low_pulse < min_pulse_reg)
                        begin
                            phase_next = PH_SYNC_FALL;
                        end
                        else
                        begin
                            pattern_start_next = fall_stamp_reg;
                            pulse_count_next   = PC_W'(1);
                            phase_next         = PH_MEAS_FALL;
                        end
                    end
                end
                PH_MEAS_FALL:
                begin
                    if (in_level_reg == LEVEL_LOW)
                    begin
                        fall_stamp_next = in_stamp_reg;
                        phase_next      = PH_MEAS_RISE;
                    end
                end
                PH_MEAS_RISE:
                begin
                    if (in_level_reg == LEVEL_HIGH)
                    begin
                        if (pulse_inc >= PC_W'(PULSES_PER_PATTERN))
                        begin
                            // pattern complete: score this trim and step on
                            pulse_count_next = '0;
                            emit             = 1'b1;
                            if (err < least_error_reg)
                            begin
                                least_error_next = err;
                                least_trim_next  = sweep_trim_reg;
                            end
                            sweep_trim_next = trim_inc;
                            if (index_inc < MI_W'(STEPS_PER_ROUND))
                            begin
                                measure_index_next = index_inc;
                                phase_next         = PH_SYNC_FALL;
                                res.kind           = KIND_APPLY;
                                res.trim_to_apply  = trim_inc;
                            end
                            else
                            begin
                                measure_index_next = '0;
                                phase_next         = PH_IDLE;
                                if (round_count_reg < max_rounds_reg)
                                begin
                                    round_count_next  = round_count_reg + 6'd1;
                                    res.kind          = KIND_CONTINUE;
                                    res.trim_to_apply = operating_trim_reg;
                                end
                                else
                                begin
                                    res.kind             = KIND_SUCCESS;
                                    res.trim_to_apply    = least_trim_next;
                                    res.correction_delta =
                                        least_trim_next - operating_trim_reg;
                                end
                            end
                        end
                        else
                        begin
                            pulse_count_next = pulse_inc;
                            phase_next       = PH_MEAS_FALL;
                        end
                    end
                end
                default:
                begin
                    // idle: edges are ignored
                end
            endcase
        end

        res.best_trim  = least_trim_next;
        res.best_error = least_error_next;
    end

    // sweep state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            pulse_count_reg   <= '0;
            pattern_start_reg <= 16'd0;
            fall_stamp_reg    <= 16'd0;
            sweep_trim_reg    <= 8'd0;
            measure_index_reg <= '0;
            round_count_reg   <= 6'd0;
            least_error_reg   <= LEAST_ERROR_INIT;
            least_trim_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            pulse_count_reg   <= pulse_count_next;
            pattern_start_reg <= pattern_start_next;
            fall_stamp_reg    <= fall_stamp_next;
            sweep_trim_reg    <= sweep_trim_next;
            measure_index_reg <= measure_index_next;
            round_count_reg   <= round_count_next;
            least_error_reg   <= least_error_next;
            least_trim_reg    <= least_trim_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= res;
        end
    end

`ifndef SYNTHESIS
    // sweep never runs past its last step
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        measure_index_reg < MI_W'(STEPS_PER_ROUND))
        else $error("measure index out of range");

    // while counting pattern pulses the count lies inside the pattern
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MEAS_FALL || phase_reg == PH_MEAS_RISE) |->
        (pulse_count_reg != '0 && pulse_count_reg < PC_W'(PULSES_PER_PATTERN)))
        else $error("pulse count out of range in measurement");

    // input side stalls only when both stages are occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("request stalled without a full pipeline");

    // success always reports the best trim as the trim to apply
    a_success_trim: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_SUCCESS) |-> (m_tdata[7:0] == m_tdata[15:8]))
        else $error("success result with trim other than best trim");
`endif

endmodule
